FILE: sv/grid_reachability_bfs_assert.svh
// ----------------------------------------------------------------------------
// Grid reachability assertion macros
// Shared property wrappers; clk and rst must be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef GRID_REACHABILITY_BFS_ASSERT_SVH
`define GRID_REACHABILITY_BFS_ASSERT_SVH

// Same-cycle implication.
`define GRB_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GRB_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/gbfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_pkg
// Sizes, types, codes and neighbor tables of the grid reachability search.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 128;
  localparam int CELLS     = GRID_COLS * GRID_ROWS;

  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int IDX_W  = $clog2(CELLS);
  localparam int QENT_W = COL_W + ROW_W;
  localparam int CR_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIM_W  = (CR_W + 1 > 8) ? CR_W + 1 : 8;

  localparam int CRD_W     = 7;
  localparam int CODE_W    = 8;
  localparam int EXB_W     = 5;
  localparam int CFG_W     = 8;
  localparam int REG_IDX_W = 3;

  // excluded area is a 4x4 block of cells
  localparam int BLOCK_SHIFT = 2;

  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [IDX_W:0]       qptr_t;
  typedef logic [QENT_W-1:0]    qent_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [CRD_W-1:0]     crd_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [EXB_W-1:0]     exb_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [3:0]           slot_t;
  typedef logic [1:0]           off_t;
  typedef logic [1:0]           rdsel_t;

  localparam reg_idx_t REG_GRID_WIDTH  = 3'd0;
  localparam reg_idx_t REG_GRID_HEIGHT = 3'd1;
  localparam reg_idx_t REG_WALL_CODE   = 3'd2;
  localparam reg_idx_t REG_BOX_CODE    = 3'd3;
  localparam reg_idx_t REG_BOMB_CODE   = 3'd4;

  localparam cfg_t RST_GRID_WIDTH  = 8'd128;
  localparam cfg_t RST_GRID_HEIGHT = 8'd128;
  localparam cfg_t RST_WALL_CODE   = 8'd1;
  localparam cfg_t RST_BOX_CODE    = 8'd2;
  localparam cfg_t RST_BOMB_CODE   = 8'd3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam rdsel_t RD_START = 2'd0;
  localparam rdsel_t RD_GOAL  = 2'd1;
  localparam rdsel_t RD_NBR   = 2'd2;

  localparam int NBR_SLOTS = 9;
  localparam int NBR_DIRS  = 8;

  // offsets stored as delta + 1
  localparam off_t DIR_OX [NBR_DIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam off_t DIR_OY [NBR_DIRS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam off_t SLOT_OX [NBR_SLOTS] =
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam off_t SLOT_OY [NBR_SLOTS] =
    '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

  localparam off_t OFF_MID = 2'd1;

  typedef struct packed {
    logic   in_ready;
    logic   occ_clr;
    logic   vis_clr;
    rdsel_t rd_sel;
    logic   cap_start;
    logic   seed;
    logic   pop;
    logic   load_cur;
    logic   nbr_issue;
    logic   eval;
    logic   respond;
    logic   res_kind;
    logic   res_reach;
    logic   cnt_clr;
    logic   cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_cmd;
    logic out_free;
    logic same;
    logic oob;
    logic start_blk;
    logic goal_blk;
    logic q_empty;
    logic hit;
    logic cnt_last_cell;
    logic cnt_nine;
    logic cnt_seven;
  } sts_t;

  function automatic idx_t cell_addr(col_t x, row_t y);
    return idx_t'(y) * idx_t'(GRID_COLS) + idx_t'(x);
  endfunction

  function automatic slot_t slot_of(off_t ox, off_t oy);
    return 4'(oy) * 4'd3 + 4'(ox);
  endfunction

endpackage

FILE: sv/gbfs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gbfs_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  gbfs_pkg::crd_t     cell_x;
  gbfs_pkg::crd_t     cell_y;
  gbfs_pkg::code_t    cell_code;
  gbfs_pkg::crd_t     start_x;
  gbfs_pkg::crd_t     start_y;
  gbfs_pkg::crd_t     goal_x;
  gbfs_pkg::crd_t     goal_y;
  logic               exclude_enable;
  gbfs_pkg::exb_t     exclude_row;
  gbfs_pkg::exb_t     exclude_col;

  modport source (output valid, command, cell_x, cell_y, cell_code, start_x, start_y,
                  goal_x, goal_y, exclude_enable, exclude_row, exclude_col,
                  input ready);
  modport sink (input valid, command, cell_x, cell_y, cell_code, start_x, start_y,
                goal_x, goal_y, exclude_enable, exclude_row, exclude_col,
                output ready);
endinterface

interface gbfs_rsp_if;
  logic valid;
  logic ready;
  logic answer_kind;
  logic reachable;

  modport source (output valid, answer_kind, reachable, input ready);
  modport sink (input valid, answer_kind, reachable, output ready);
endinterface

interface gbfs_cfg_if;
  logic                valid;
  logic                ready;
  gbfs_pkg::reg_idx_t  index;
  gbfs_pkg::cfg_t      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/grid_reachability_bfs.sv
// Sequence: a write goes from acceptance to the response state; a query with equal
//   start/goal or a cell off the grid is settled by the query check; a full search
//   clears visited, then per queued cell does nine grid reads and eight neighbor checks.
// Flow: one transaction at a time; a finished response waits in its output register.
// Reset: a clearing pass over every cell zeroes the grid; register writes
//   are taken during it.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_reachability_bfs
// 8-connected breadth-first reachability over a stored occupancy grid.
// ----------------------------------------------------------------------------
module grid_reachability_bfs (
  input  logic       clk,
  input  logic       rst,
  gbfs_req_if.sink   req,
  gbfs_rsp_if.source rsp,
  gbfs_cfg_if.sink   cfg
);

  gbfs_pkg::cmd_t cmd;
  gbfs_pkg::sts_t sts;

  gbfs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gbfs_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: sv/gbfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gbfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Sequencer: reset sweep, query checks, visited clear, queue walk.
// ----------------------------------------------------------------------------
module gbfs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  gbfs_pkg::sts_t sts,
  output gbfs_pkg::cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QCHK  = 4'd2;
  localparam logic [3:0] S_RDG   = 4'd3;
  localparam logic [3:0] S_BCHK  = 4'd4;
  localparam logic [3:0] S_CLR   = 4'd5;
  localparam logic [3:0] S_SEED  = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_FETCH = 4'd8;
  localparam logic [3:0] S_LOAD  = 4'd9;
  localparam logic [3:0] S_EVAL  = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0] state, state_next;
  logic       res_kind, res_kind_next;
  logic       res_reach, res_reach_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
    res_kind  <= res_kind_next;
    res_reach <= res_reach_next;
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = gbfs_pkg::RD_NBR;
    cmd.res_kind   = res_kind;
    cmd.res_reach  = res_reach;
    state_next     = state;
    res_kind_next  = res_kind;
    res_reach_next = res_reach;
    case (state)
      S_INIT: begin
        cmd.occ_clr = 1'b1;
        cmd.vis_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_cell) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.req_valid) begin
          if (sts.req_cmd == gbfs_pkg::CMD_WRITE) begin
            res_kind_next  = gbfs_pkg::KIND_WRITE;
            res_reach_next = 1'b0;
            state_next     = S_RESP;
          end else begin
            state_next = S_QCHK;
          end
        end
      end
      S_QCHK: begin
        res_kind_next = gbfs_pkg::KIND_QUERY;
        if (sts.same) begin
          res_reach_next = 1'b1;
          state_next     = S_RESP;
        end else if (sts.oob) begin
          res_reach_next = 1'b0;
          state_next     = S_RESP;
        end else begin
          cmd.rd_sel = gbfs_pkg::RD_START;
          state_next = S_RDG;
        end
      end
      S_RDG: begin
        cmd.rd_sel    = gbfs_pkg::RD_GOAL;
        cmd.cap_start = 1'b1;
        state_next    = S_BCHK;
      end
      S_BCHK: begin
        if (sts.start_blk || sts.goal_blk) begin
          res_reach_next = 1'b0;
          state_next     = S_RESP;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_CLR;
        end
      end
      S_CLR: begin
        cmd.vis_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_cell) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          res_reach_next = 1'b0;
          state_next     = S_RESP;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.load_cur = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        // nine reads of the 3x3 window, data lands in the next cycle
        if (sts.cnt_nine) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_EVAL;
        end else begin
          cmd.nbr_issue = 1'b1;
          cmd.cnt_inc   = 1'b1;
        end
      end
      S_EVAL: begin
        cmd.eval    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.hit) begin
          res_reach_next = 1'b1;
          state_next     = S_RESP;
        end else if (sts.cnt_seven) begin
          state_next = S_POP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

FILE: sv/gbfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_datapath
// Registers, grid/visited/queue memories, neighbor window and result register.
// ----------------------------------------------------------------------------
module gbfs_datapath (
  input  logic           clk,
  input  logic           rst,
  gbfs_req_if.sink       req,
  gbfs_rsp_if.source     rsp,
  gbfs_cfg_if.sink       cfg,
  input  gbfs_pkg::cmd_t cmd,
  output gbfs_pkg::sts_t sts
);

  gbfs_pkg::cfg_t grid_width, grid_height, wall_code, box_code, bomb_code;

  gbfs_pkg::crd_t q_sx, q_sy, q_gx, q_gy;
  logic           q_excl;
  gbfs_pkg::exb_t q_exr, q_exc;

  gbfs_pkg::col_t  cur_x;
  gbfs_pkg::row_t  cur_y;
  gbfs_pkg::qptr_t head, tail;
  gbfs_pkg::idx_t  cnt;

  logic                            cap_en;
  gbfs_pkg::slot_t                 cap_slot;
  logic [gbfs_pkg::NBR_SLOTS-1:0]  nb_blk, nb_vis;
  logic                            start_blk;

  logic rsp_valid, rsp_kind, rsp_reach;

  gbfs_pkg::code_t occ_rdata;
  logic            vis_rdata;
  gbfs_pkg::qent_t q_rdata;

  logic occ_we, vis_we, q_we, vis_wdata;
  gbfs_pkg::idx_t  occ_waddr, occ_raddr, vis_waddr, q_waddr, q_raddr;
  gbfs_pkg::code_t occ_wdata;
  gbfs_pkg::qent_t q_wdata;

  logic           fire, wr_fire, occ_blk;
  gbfs_pkg::dim_t w_lim, h_lim;
  gbfs_pkg::col_t s_col, g_col;
  gbfs_pkg::row_t s_row, g_row;
  gbfs_pkg::idx_t start_addr, goal_addr;

  // window load
  gbfs_pkg::slot_t         ld_k;
  logic [gbfs_pkg::COL_W:0] ld_px;
  logic [gbfs_pkg::ROW_W:0] ld_py;
  logic                    ld_ok;
  gbfs_pkg::idx_t          ld_addr;

  // neighbor evaluation
  logic [2:0]               ev_d;
  gbfs_pkg::off_t           ev_ox, ev_oy;
  logic [gbfs_pkg::COL_W:0] ev_px;
  logic [gbfs_pkg::ROW_W:0] ev_py;
  gbfs_pkg::col_t           nx;
  gbfs_pkg::row_t           ny;
  gbfs_pkg::slot_t          ev_s, ev_sx, ev_sy;
  logic ev_rng, ev_diag, ev_excl, ev_ok, ev_goal, mark;
  gbfs_pkg::idx_t           nbr_addr;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gbfs_pkg::RST_GRID_WIDTH;
      grid_height <= gbfs_pkg::RST_GRID_HEIGHT;
      wall_code   <= gbfs_pkg::RST_WALL_CODE;
      box_code    <= gbfs_pkg::RST_BOX_CODE;
      bomb_code   <= gbfs_pkg::RST_BOMB_CODE;
    end else if (cfg.valid) begin
      case (cfg.index)
        gbfs_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data;
        gbfs_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data;
        gbfs_pkg::REG_WALL_CODE:   wall_code   <= cfg.data;
        gbfs_pkg::REG_BOX_CODE:    box_code    <= cfg.data;
        gbfs_pkg::REG_BOMB_CODE:   bomb_code   <= cfg.data;
        default: ;
      endcase
    end
  end

  // request capture
  assign req.ready = cmd.in_ready;
  assign fire      = req.valid && cmd.in_ready;
  assign wr_fire   = fire && (req.command == gbfs_pkg::CMD_WRITE) &&
                     (gbfs_pkg::dim_t'(req.cell_x) < gbfs_pkg::dim_t'(gbfs_pkg::GRID_COLS)) &&
                     (gbfs_pkg::dim_t'(req.cell_y) < gbfs_pkg::dim_t'(gbfs_pkg::GRID_ROWS));

  always_ff @(posedge clk) begin
    if (fire) begin
      q_sx   <= req.start_x;
      q_sy   <= req.start_y;
      q_gx   <= req.goal_x;
      q_gy   <= req.goal_y;
      q_excl <= req.exclude_enable;
      q_exr  <= req.exclude_row;
      q_exc  <= req.exclude_col;
    end
  end

  assign w_lim = (gbfs_pkg::dim_t'(grid_width) < gbfs_pkg::dim_t'(gbfs_pkg::GRID_COLS)) ?
                 gbfs_pkg::dim_t'(grid_width) : gbfs_pkg::dim_t'(gbfs_pkg::GRID_COLS);
  assign h_lim = (gbfs_pkg::dim_t'(grid_height) < gbfs_pkg::dim_t'(gbfs_pkg::GRID_ROWS)) ?
                 gbfs_pkg::dim_t'(grid_height) : gbfs_pkg::dim_t'(gbfs_pkg::GRID_ROWS);

  assign s_col      = gbfs_pkg::col_t'(q_sx);
  assign s_row      = gbfs_pkg::row_t'(q_sy);
  assign g_col      = gbfs_pkg::col_t'(q_gx);
  assign g_row      = gbfs_pkg::row_t'(q_gy);
  assign start_addr = gbfs_pkg::cell_addr(s_col, s_row);
  assign goal_addr  = gbfs_pkg::cell_addr(g_col, g_row);

  assign occ_blk = (occ_rdata == wall_code) || (occ_rdata == box_code) ||
                   (occ_rdata == bomb_code);

  // window load: slot k covers offset (SLOT_OX[k]-1, SLOT_OY[k]-1)
  assign ld_k    = (cnt[3:0] < 4'(gbfs_pkg::NBR_SLOTS)) ? cnt[3:0] : '0;
  assign ld_px   = {1'b0, cur_x} + (gbfs_pkg::COL_W + 1)'(gbfs_pkg::SLOT_OX[ld_k]);
  assign ld_py   = {1'b0, cur_y} + (gbfs_pkg::ROW_W + 1)'(gbfs_pkg::SLOT_OY[ld_k]);
  assign ld_ok   = (ld_px != '0) && (gbfs_pkg::dim_t'(ld_px) <= w_lim) &&
                   (ld_py != '0) && (gbfs_pkg::dim_t'(ld_py) <= h_lim);
  assign ld_addr = ld_ok ? gbfs_pkg::cell_addr(gbfs_pkg::col_t'(ld_px - 1'b1),
                                               gbfs_pkg::row_t'(ld_py - 1'b1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_en <= 1'b0;
    end else begin
      cap_en <= cmd.nbr_issue;
    end
    cap_slot <= ld_k;
    if (cap_en) begin
      nb_blk[cap_slot] <= occ_blk;
      nb_vis[cap_slot] <= vis_rdata;
    end
    if (cmd.cap_start) begin
      start_blk <= occ_blk;
    end
    if (cmd.load_cur) begin
      {cur_y, cur_x} <= q_rdata;
    end
  end

  // neighbor evaluation, one direction a cycle
  assign ev_d    = cnt[2:0];
  assign ev_ox   = gbfs_pkg::DIR_OX[ev_d];
  assign ev_oy   = gbfs_pkg::DIR_OY[ev_d];
  assign ev_px   = {1'b0, cur_x} + (gbfs_pkg::COL_W + 1)'(ev_ox);
  assign ev_py   = {1'b0, cur_y} + (gbfs_pkg::ROW_W + 1)'(ev_oy);
  assign nx      = gbfs_pkg::col_t'(ev_px - 1'b1);
  assign ny      = gbfs_pkg::row_t'(ev_py - 1'b1);
  assign ev_rng  = (ev_px != '0) && (gbfs_pkg::dim_t'(ev_px) <= w_lim) &&
                   (ev_py != '0) && (gbfs_pkg::dim_t'(ev_py) <= h_lim);
  assign ev_s    = gbfs_pkg::slot_of(ev_ox, ev_oy);
  assign ev_sx   = gbfs_pkg::slot_of(ev_ox, gbfs_pkg::OFF_MID);
  assign ev_sy   = gbfs_pkg::slot_of(gbfs_pkg::OFF_MID, ev_oy);
  assign ev_diag = (ev_ox != gbfs_pkg::OFF_MID) && (ev_oy != gbfs_pkg::OFF_MID);
  assign ev_excl = q_excl &&
                   (gbfs_pkg::dim_t'(ny >> gbfs_pkg::BLOCK_SHIFT) == gbfs_pkg::dim_t'(q_exr)) &&
                   (gbfs_pkg::dim_t'(nx >> gbfs_pkg::BLOCK_SHIFT) == gbfs_pkg::dim_t'(q_exc));
  // corner cutting is refused when either side cell is blocked
  assign ev_ok   = ev_rng && !nb_vis[ev_s] && !ev_excl &&
                   !(ev_diag && (nb_blk[ev_sx] || nb_blk[ev_sy])) && !nb_blk[ev_s];
  assign ev_goal = (gbfs_pkg::dim_t'(nx) == gbfs_pkg::dim_t'(q_gx)) &&
                   (gbfs_pkg::dim_t'(ny) == gbfs_pkg::dim_t'(q_gy));
  assign mark     = cmd.eval && ev_ok && !ev_goal;
  assign nbr_addr = gbfs_pkg::cell_addr(nx, ny);

  // queue pointers and shared counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.seed) begin
        head <= '0;
        tail <= gbfs_pkg::qptr_t'(1);
      end else begin
        if (cmd.pop) begin
          head <= head + 1'b1;
        end
        if (mark) begin
          tail <= tail + 1'b1;
        end
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // memories
  assign occ_we    = cmd.occ_clr || wr_fire;
  assign occ_waddr = cmd.occ_clr ? cnt :
                     gbfs_pkg::cell_addr(gbfs_pkg::col_t'(req.cell_x),
                                         gbfs_pkg::row_t'(req.cell_y));
  assign occ_wdata = cmd.occ_clr ? '0 : req.cell_code;

  always_comb begin
    case (cmd.rd_sel)
      gbfs_pkg::RD_START: occ_raddr = start_addr;
      gbfs_pkg::RD_GOAL:  occ_raddr = goal_addr;
      gbfs_pkg::RD_NBR:   occ_raddr = ld_addr;
      default:            occ_raddr = ld_addr;
    endcase
  end

  assign vis_we    = cmd.vis_clr || cmd.seed || mark;
  assign vis_waddr = cmd.vis_clr ? cnt : (cmd.seed ? start_addr : nbr_addr);
  assign vis_wdata = !cmd.vis_clr;

  assign q_we    = cmd.seed || mark;
  assign q_waddr = cmd.seed ? '0 : tail[gbfs_pkg::IDX_W-1:0];
  assign q_wdata = cmd.seed ? {s_row, s_col} : {ny, nx};
  assign q_raddr = head[gbfs_pkg::IDX_W-1:0];

  gbfs_ram #(.WIDTH(gbfs_pkg::CODE_W), .DEPTH(gbfs_pkg::CELLS)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  gbfs_ram #(.WIDTH(1), .DEPTH(gbfs_pkg::CELLS)) u_vis (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (ld_addr),
    .rdata (vis_rdata)
  );

  gbfs_ram #(.WIDTH(gbfs_pkg::QENT_W), .DEPTH(gbfs_pkg::CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.respond) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.respond) begin
      rsp_kind  <= cmd.res_kind;
      rsp_reach <= cmd.res_reach;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.answer_kind = rsp_kind;
  assign rsp.reachable   = rsp_reach;

  // status
  assign sts.req_valid     = req.valid;
  assign sts.req_cmd       = req.command;
  assign sts.out_free      = !rsp_valid || rsp.ready;
  assign sts.same          = (q_sx == q_gx) && (q_sy == q_gy);
  assign sts.oob           = (gbfs_pkg::dim_t'(q_sx) >= w_lim) ||
                             (gbfs_pkg::dim_t'(q_sy) >= h_lim) ||
                             (gbfs_pkg::dim_t'(q_gx) >= w_lim) ||
                             (gbfs_pkg::dim_t'(q_gy) >= h_lim);
  assign sts.start_blk     = start_blk;
  assign sts.goal_blk      = occ_blk;
  assign sts.q_empty       = (head == tail);
  assign sts.hit           = cmd.eval && ev_ok && ev_goal;
  assign sts.cnt_last_cell = (cnt == gbfs_pkg::idx_t'(gbfs_pkg::CELLS - 1));
  assign sts.cnt_nine      = (cnt == gbfs_pkg::idx_t'(gbfs_pkg::NBR_SLOTS));
  assign sts.cnt_seven     = (cnt == gbfs_pkg::idx_t'(gbfs_pkg::NBR_DIRS - 1));

endmodule

FILE: sv/gbfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_checker
// Port-level checks on the grid reachability block.
// ----------------------------------------------------------------------------
`include "grid_reachability_bfs_assert.svh"

module gbfs_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic answer_kind,
  input logic reachable
);

  // response holds while stalled
  `GRB_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(answer_kind) && $stable(reachable), "response changed while stalled")

  // one transaction in flight
  `GRB_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

  // write acknowledge never claims reachability
  `GRB_IMPLIES(a_write_ack, rsp_valid && (answer_kind == gbfs_pkg::KIND_WRITE), !reachable, "write ack with reachable set")

  // grid clearing pass follows reset
  `GRB_IMPLIES(a_init_busy, $fell(rst), !req_ready, "request taken during reset clear")

endmodule

bind grid_reachability_bfs gbfs_checker u_gbfs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .answer_kind (rsp.answer_kind),
  .reachable   (rsp.reachable)
);

FILE: tb/tb_grid_reachability_bfs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_reachability_bfs
// Self-checking bench for the grid reachability search. Cell writes and
// queries go in on the request channel. A local breadth-first predictor keeps
// its own copy of the grid and the registers and checks every response in
// order. The run covers directed corner cases, then random traffic under three
// stall patterns.
// ----------------------------------------------------------------------------
module tb_grid_reachability_bfs;
  import gbfs_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 12_000_000;
  localparam int PHASE_OPS  = 26;

  typedef struct {
    logic  cmd;
    crd_t  cx, cy;
    code_t code;
    crd_t  sx, sy, gx, gy;
    logic  ex_en;
    exb_t  er, ec;
  } grid_op_t;

  typedef struct {
    logic kind;
    logic reach;
  } answer_t;

  logic clk;
  logic rst;

  gbfs_req_if req ();
  gbfs_rsp_if rsp ();
  gbfs_cfg_if cfg ();

  grid_reachability_bfs DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // local copy of block state
  code_t occ_mirror [CELLS];
  bit    seen_map   [CELLS];
  cfg_t  width_reg, height_reg, wall_reg, box_reg, bomb_reg;

  grid_op_t op_pending  [$];
  answer_t  answers_due [$];

  int  src_idle;
  int  snk_idle;
  bit  req_took;
  bit  failed;
  int  cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit cell_blocked(int x, int y);
    code_t c;
    c = occ_mirror[y * GRID_COLS + x];
    return (c == wall_reg) || (c == box_reg) || (c == bomb_reg);
  endfunction

  function automatic int active_cols();
    return (int'(width_reg) < GRID_COLS) ? int'(width_reg) : GRID_COLS;
  endfunction

  function automatic int active_rows();
    return (int'(height_reg) < GRID_ROWS) ? int'(height_reg) : GRID_ROWS;
  endfunction

  function automatic bit predict_reach(grid_op_t op);
    int w, h, cur, x, y, nx, ny, ni, dx, dy;
    int frontier [$];
    w = active_cols();
    h = active_rows();
    if (op.sx == op.gx && op.sy == op.gy) return 1'b1;
    if (op.sx >= w || op.sy >= h || op.gx >= w || op.gy >= h) return 1'b0;
    if (cell_blocked(op.sx, op.sy) || cell_blocked(op.gx, op.gy)) return 1'b0;
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    cur = int'(op.sy) * GRID_COLS + int'(op.sx);
    frontier.push_back(cur);
    seen_map[cur] = 1'b1;
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      x = cur % GRID_COLS;
      y = cur / GRID_COLS;
      for (int d = 0; d < 8; d++) begin
        dx = (d < 3) ? -1 : ((d < 5) ? 0 : 1);
        dy = (d == 0 || d == 3 || d == 5) ? -1 : ((d == 1 || d == 6) ? 0 : 1);
        nx = x + dx;
        ny = y + dy;
        if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
        ni = ny * GRID_COLS + nx;
        if (seen_map[ni]) continue;
        if (op.ex_en && (ny / 4 == op.er) && (nx / 4 == op.ec)) continue;
        // corner cutting is refused if either side cell is blocked
        if (dx != 0 && dy != 0 && (cell_blocked(nx, y) || cell_blocked(x, ny))) continue;
        if (cell_blocked(nx, ny)) continue;
        if (nx == op.gx && ny == op.gy) return 1'b1;
        seen_map[ni] = 1'b1;
        frontier.push_back(ni);
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t apply_op(grid_op_t op);
    answer_t a;
    if (op.cmd == CMD_WRITE) begin
      occ_mirror[int'(op.cy) * GRID_COLS + int'(op.cx)] = op.code;
      a.kind  = KIND_WRITE;
      a.reach = 1'b0;
    end else begin
      a.kind  = KIND_QUERY;
      a.reach = predict_reach(op);
    end
    return a;
  endfunction

  function automatic grid_op_t write_op(int x, int y, code_t c);
    grid_op_t op;
    op = '{default: '0};
    op.cmd  = CMD_WRITE;
    op.cx   = crd_t'(x);
    op.cy   = crd_t'(y);
    op.code = c;
    return op;
  endfunction

  function automatic grid_op_t query_op(int sx, int sy, int gx, int gy,
                                        bit en, int er, int ec);
    grid_op_t op;
    op = '{default: '0};
    op.cmd   = CMD_QUERY;
    op.sx    = crd_t'(sx);
    op.sy    = crd_t'(sy);
    op.gx    = crd_t'(gx);
    op.gy    = crd_t'(gy);
    op.ex_en = en;
    op.er    = exb_t'(er);
    op.ec    = exb_t'(ec);
    return op;
  endfunction

  function automatic code_t pick_code();
    case ($urandom_range(5))
      0, 1:    return '0;
      2:       return wall_reg;
      3:       return box_reg;
      4:       return bomb_reg;
      default: return code_t'($urandom);
    endcase
  endfunction

  // mostly well-formed traffic inside the active grid, some raw noise
  function automatic grid_op_t random_op();
    grid_op_t op;
    int w, h, r;
    w = (active_cols() > 0) ? active_cols() : 1;
    h = (active_rows() > 0) ? active_rows() : 1;
    op.cmd   = logic'($urandom);
    op.cx    = crd_t'($urandom);
    op.cy    = crd_t'($urandom);
    op.code  = code_t'($urandom);
    op.sx    = crd_t'($urandom);
    op.sy    = crd_t'($urandom);
    op.gx    = crd_t'($urandom);
    op.gy    = crd_t'($urandom);
    op.ex_en = logic'($urandom);
    op.er    = exb_t'($urandom);
    op.ec    = exb_t'($urandom);
    r = $urandom_range(99);
    if (r < 6) return op;
    if (r < 45) begin
      op.cmd  = CMD_WRITE;
      op.cx   = crd_t'($urandom_range(w - 1));
      op.cy   = crd_t'($urandom_range(h - 1));
      op.code = pick_code();
    end else begin
      op.cmd = CMD_QUERY;
      op.sx  = crd_t'($urandom_range(w - 1));
      op.sy  = crd_t'($urandom_range(h - 1));
      op.gx  = crd_t'($urandom_range(w - 1));
      op.gy  = crd_t'($urandom_range(h - 1));
      r = $urandom_range(99);
      if (r < 10) begin
        op.gx = op.sx;
        op.gy = op.sy;
      end else if (r < 20) begin
        op.gx = crd_t'($urandom);
      end
      if ($urandom_range(99) < 70) begin
        op.ex_en = ($urandom_range(99) < 40);
        op.er    = exb_t'($urandom_range((h - 1) / 4));
        op.ec    = exb_t'($urandom_range((w - 1) / 4));
      end
    end
    return op;
  endfunction

  // request driver and response stall
  always @(negedge clk) begin
    grid_op_t op;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      if (!req.valid || req_took) begin
        if (op_pending.size() > 0 && $urandom_range(99) >= src_idle) begin
          op = op_pending.pop_front();
          req.command        <= op.cmd;
          req.cell_x         <= op.cx;
          req.cell_y         <= op.cy;
          req.cell_code      <= op.code;
          req.start_x        <= op.sx;
          req.start_y        <= op.sy;
          req.goal_x         <= op.gx;
          req.goal_y         <= op.gy;
          req.exclude_enable <= op.ex_en;
          req.exclude_row    <= op.er;
          req.exclude_col    <= op.ec;
          req.valid          <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    grid_op_t op;
    answer_t  want;
    req_took = req.valid && req.ready && !rst;
    if (req_took) begin
      op.cmd   = req.command;
      op.cx    = req.cell_x;
      op.cy    = req.cell_y;
      op.code  = req.cell_code;
      op.sx    = req.start_x;
      op.sy    = req.start_y;
      op.gx    = req.goal_x;
      op.gy    = req.goal_y;
      op.ex_en = req.exclude_enable;
      op.er    = req.exclude_row;
      op.ec    = req.exclude_col;
      answers_due.push_back(apply_op(op));
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected response kind=%0b reachable=%0b",
                 $time, rsp.answer_kind, rsp.reachable);
        failed = 1'b1;
      end else begin
        want = answers_due.pop_front();
        if (rsp.answer_kind !== want.kind) begin
          $display("%0t: answer_kind mismatch expected=%0b actual=%0b",
                   $time, want.kind, rsp.answer_kind);
          failed = 1'b1;
        end
        if (rsp.reachable !== want.reach) begin
          $display("%0t: reachable mismatch expected=%0b actual=%0b",
                   $time, want.reach, rsp.reachable);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, cfg_t val);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_GRID_WIDTH:  width_reg  = val;
      REG_GRID_HEIGHT: height_reg = val;
      REG_WALL_CODE:   wall_reg   = val;
      REG_BOX_CODE:    box_reg    = val;
      REG_BOMB_CODE:   bomb_reg   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_all(cfg_t w, cfg_t h, cfg_t wc, cfg_t bc, cfg_t mc);
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cfg_write(REG_WALL_CODE, wc);
    cfg_write(REG_BOX_CODE, bc);
    cfg_write(REG_BOMB_CODE, mc);
  endtask

  // sender holds off until every outstanding transaction is answered
  task automatic drain();
    while (op_pending.size() > 0 || req.valid || answers_due.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_phase(int s_idle, int r_idle);
    src_idle = s_idle;
    snk_idle = r_idle;
    repeat (PHASE_OPS) op_pending.push_back(random_op());
    drain();
  endtask

  initial begin
    failed     = 1'b0;
    cycle_cnt  = 0;
    req_took   = 1'b0;
    src_idle   = 0;
    snk_idle   = 0;
    width_reg  = RST_GRID_WIDTH;
    height_reg = RST_GRID_HEIGHT;
    wall_reg   = RST_WALL_CODE;
    box_reg    = RST_BOX_CODE;
    bomb_reg   = RST_BOMB_CODE;
    foreach (occ_mirror[i]) occ_mirror[i] = '0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_WRITE;
    req.cell_x = '0;
    req.cell_y = '0;
    req.cell_code = '0;
    req.start_x = '0;
    req.start_y = '0;
    req.goal_x = '0;
    req.goal_y = '0;
    req.exclude_enable = 1'b0;
    req.exclude_row = '0;
    req.exclude_col = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-size grid at reset settings
    op_pending.push_back(query_op(127, 127, 127, 127, 0, 0, 0));
    op_pending.push_back(write_op(127, 0, RST_WALL_CODE));
    op_pending.push_back(write_op(0, 127, 8'd255));
    op_pending.push_back(write_op(5, 5, RST_BOMB_CODE));
    op_pending.push_back(write_op(6, 6, RST_BOX_CODE));
    op_pending.push_back(query_op(5, 5, 0, 0, 0, 0, 0));
    op_pending.push_back(query_op(0, 0, 6, 6, 0, 0, 0));
    op_pending.push_back(query_op(5, 5, 5, 5, 0, 0, 0));
    op_pending.push_back(query_op(0, 0, 127, 127, 1, 31, 0));
    drain();

    // tiny grid: corner cutting, exclusion, off-grid cells
    set_all(8'd3, 8'd3, 8'd7, 8'd8, 8'd9);
    op_pending.push_back(write_op(1, 0, 8'd7));
    op_pending.push_back(write_op(0, 1, 8'd8));
    op_pending.push_back(query_op(0, 0, 2, 2, 0, 0, 0));
    op_pending.push_back(query_op(2, 2, 1, 1, 0, 0, 0));
    op_pending.push_back(query_op(2, 2, 1, 1, 1, 0, 0));
    op_pending.push_back(query_op(2, 2, 3, 3, 0, 0, 0));
    op_pending.push_back(query_op(100, 90, 100, 90, 0, 0, 0));
    op_pending.push_back(write_op(1, 0, 8'd0));
    op_pending.push_back(query_op(0, 0, 2, 2, 0, 0, 0));
    drain();

    // degenerate sizes and extreme codes
    set_all(8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    op_pending.push_back(query_op(0, 0, 1, 1, 0, 0, 0));
    op_pending.push_back(query_op(4, 4, 4, 4, 0, 0, 0));
    drain();
    set_all(8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    op_pending.push_back(query_op(0, 0, 1, 1, 0, 0, 0));
    drain();

    set_all(8'd6, 8'd6, 8'd1, 8'd2, 8'd3);
    random_phase(25, 45);
    set_all(8'd10, 8'd7, 8'd255, 8'd4, 8'd9);
    random_phase(45, 25);
    set_all(8'd12, 8'd12, 8'd200, 8'd17, 8'd5);
    random_phase(0, 0);

    if (!failed && answers_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
